// File: rtl/ufe_pkg.sv
package ufe_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND     = 8'h62;
    localparam logic [16:0] FRAME_OVERHEAD  = 17'd8;
    localparam logic [16:0] MAX_FRAME_RESET = 17'd65543;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  first_byte;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic        last;
    } cmd_t;

    typedef enum logic [2:0] {
        STEP_SYNC_FIRST  = 3'd0,
        STEP_SYNC_SECOND = 3'd1,
        STEP_CLASS       = 3'd2,
        STEP_ID          = 3'd3,
        STEP_LEN_LOW     = 3'd4,
        STEP_LEN_HIGH    = 3'd5,
        STEP_SUM_A       = 3'd6,
        STEP_SUM_B       = 3'd7
    } start_step_t;

    typedef enum logic [2:0] {
        DSTEP_DATA  = 3'd0,
        DSTEP_SUM_A = 3'd1,
        DSTEP_SUM_B = 3'd2
    } data_step_t;

endpackage

// File: rtl/ufe_in_if.sv
interface ufe_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;

    modport source (
        output valid, op, msg_class, msg_id, payload_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, op, msg_class, msg_id, payload_length, data_byte,
        output ready
    );
endinterface

// File: rtl/ufe_out_if.sv
interface ufe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       too_long;

    modport source (
        output valid, out_byte, frame_end, too_long,
        input  ready
    );
    modport sink (
        input  valid, out_byte, frame_end, too_long,
        output ready
    );
endinterface

// File: rtl/ufe_front.sv
module ufe_front (
    input  logic          clk,
    input  logic          rst_n,
    ufe_in_if.sink        item,
    input  logic [16:0]   max_frame_bytes,
    input  logic          q_full,
    output logic          push,
    output ufe_pkg::cmd_t push_cmd
);

    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        in_frame_reg, in_frame_next;
    logic        dropping_reg, dropping_next;
    logic        accept;
    logic        too_long;
    logic        len_zero;
    logic        last_byte;

    assign item.ready = !q_full;
    assign accept     = item.valid && !q_full;
    assign too_long   = ({1'b0, item.payload_length} + ufe_pkg::FRAME_OVERHEAD) > max_frame_bytes;
    assign len_zero   = (item.payload_length == 16'd0);
    assign last_byte  = (bytes_left_reg == 16'd1);

    always_comb
    begin
        bytes_left_next         = bytes_left_reg;
        in_frame_next           = in_frame_reg;
        dropping_next           = dropping_reg;
        push                    = 1'b0;
        push_cmd.kind           = ufe_pkg::CMD_DATA;
        push_cmd.first_byte     = item.data_byte;
        push_cmd.msg_id         = item.msg_id;
        push_cmd.payload_length = item.payload_length;
        push_cmd.last           = last_byte;
        if (accept)
        begin
            if (item.op == 1'b0)
            begin
                bytes_left_next     = item.payload_length;
                in_frame_next       = !too_long && !len_zero;
                dropping_next       = too_long && !len_zero;
                push                = 1'b1;
                push_cmd.kind       = too_long ? ufe_pkg::CMD_ERROR : ufe_pkg::CMD_START;
                push_cmd.first_byte = item.msg_class;
                push_cmd.last       = len_zero;
            end
            else if (dropping_reg)
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
                if (last_byte)
                begin
                    dropping_next = 1'b0;
                end
            end
            else if (in_frame_reg)
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
                push            = 1'b1;
                if (last_byte)
                begin
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 16'd0;
            in_frame_reg   <= 1'b0;
            dropping_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            in_frame_reg   <= in_frame_next;
            dropping_reg   <= dropping_next;
        end
    end

endmodule

// File: rtl/ufe_cmd_queue.sv
module ufe_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ufe_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output ufe_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ufe_pkg::cmd_t    entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ufe_back.sv
module ufe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ufe_pkg::cmd_t head_cmd,
    output logic          pop,
    ufe_out_if.source     result
);

    logic [2:0] step_reg, step_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;
    logic       too_long_reg;
    logic       fire;
    logic       final_step;
    logic       add_en;
    logic       clear_sums;
    logic [7:0] sel_byte;
    logic       sel_end;
    logic       sel_err;
    logic [7:0] base_a;
    logic [7:0] base_b;

    assign fire = !q_empty && (!out_valid_reg || result.ready);
    assign pop  = fire && final_step;

    always_comb
    begin
        sel_byte   = 8'd0;
        sel_end    = 1'b0;
        sel_err    = 1'b0;
        add_en     = 1'b0;
        clear_sums = 1'b0;
        final_step = 1'b0;
        unique case (head_cmd.kind)
            ufe_pkg::CMD_ERROR:
            begin
                sel_end    = 1'b1;
                sel_err    = 1'b1;
                final_step = 1'b1;
            end
            ufe_pkg::CMD_START:
            begin
                final_step = head_cmd.last ? (step_reg == ufe_pkg::STEP_SUM_B)
                                           : (step_reg == ufe_pkg::STEP_LEN_HIGH);
                unique case (step_reg)
                    ufe_pkg::STEP_SYNC_FIRST:
                    begin
                        sel_byte   = ufe_pkg::SYNC_FIRST;
                        clear_sums = 1'b1;
                    end
                    ufe_pkg::STEP_SYNC_SECOND:
                    begin
                        sel_byte = ufe_pkg::SYNC_SECOND;
                    end
                    ufe_pkg::STEP_CLASS:
                    begin
                        sel_byte = head_cmd.first_byte;
                        add_en   = 1'b1;
                    end
                    ufe_pkg::STEP_ID:
                    begin
                        sel_byte = head_cmd.msg_id;
                        add_en   = 1'b1;
                    end
                    ufe_pkg::STEP_LEN_LOW:
                    begin
                        sel_byte = head_cmd.payload_length[7:0];
                        add_en   = 1'b1;
                    end
                    ufe_pkg::STEP_LEN_HIGH:
                    begin
                        sel_byte = head_cmd.payload_length[15:8];
                        add_en   = 1'b1;
                    end
                    ufe_pkg::STEP_SUM_A:
                    begin
                        sel_byte = sum_a_reg;
                    end
                    default:
                    begin
                        sel_byte = sum_b_reg;
                        sel_end  = 1'b1;
                    end
                endcase
            end
            ufe_pkg::CMD_DATA:
            begin
                final_step = head_cmd.last ? (step_reg == ufe_pkg::DSTEP_SUM_B)
                                           : (step_reg == ufe_pkg::DSTEP_DATA);
                unique case (step_reg)
                    ufe_pkg::DSTEP_DATA:
                    begin
                        sel_byte = head_cmd.first_byte;
                        add_en   = 1'b1;
                    end
                    ufe_pkg::DSTEP_SUM_A:
                    begin
                        sel_byte = sum_a_reg;
                    end
                    default:
                    begin
                        sel_byte = sum_b_reg;
                        sel_end  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        base_a         = clear_sums ? 8'd0 : sum_a_reg;
        base_b         = clear_sums ? 8'd0 : sum_b_reg;
        sum_a_next     = base_a;
        sum_b_next     = base_b;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (fire)
        begin
            out_valid_next = 1'b1;
            step_next      = final_step ? 3'd0 : step_reg + 3'd1;
            if (add_en)
            begin
                sum_a_next = base_a + sel_byte;
                sum_b_next = base_b + sum_a_next;
            end
        end
        else
        begin
            sum_a_next = sum_a_reg;
            sum_b_next = sum_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg  <= sel_byte;
            frame_end_reg <= sel_end;
            too_long_reg  <= sel_err;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_byte  = out_byte_reg;
    assign result.frame_end = frame_end_reg;
    assign result.too_long  = too_long_reg;

endmodule

// File: rtl/ubx_frame_encoder_core.sv
// Channel | Direction | Payload
// item    | in        | op, msg_class, msg_id, payload_length, data_byte
// result  | out       | out_byte, frame_end, too_long
// config  | in        | cfg_we, cfg_wdata (max_frame_bytes, 17 bits)
//
// The front accepts one transaction per cycle while the command queue has room.
// The back sends one result byte per cycle unless stalled or idle: a start gives 6
// bytes (8 when empty), a payload byte 1 (3 when the last), an oversized start 1.
// Reset is asynchronous and clears the frame state, the queue and the checksum.
// A stalled result holds in the output register while the queue keeps filling.
module ubx_frame_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ufe_in_if.sink      item,
    ufe_out_if.source   result,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);

    logic [16:0]   max_frame_reg;
    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    ufe_pkg::cmd_t push_cmd;
    ufe_pkg::cmd_t head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= ufe_pkg::MAX_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            max_frame_reg <= cfg_wdata;
        end
    end

    ufe_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .max_frame_bytes (max_frame_reg),
        .q_full          (q_full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ufe_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    ufe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head_cmd (head_cmd),
        .pop      (pop),
        .result   (result)
    );

endmodule
